/* src/vtk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtk_pkg
// Shared types, codes and helpers of the vector table k-nearest search core.
// ----------------------------------------------------------------------------
package vtk_pkg;

  localparam int ID_W       = 32;
  localparam int DIST_W     = 38;
  localparam int ELEM_W     = 16;
  localparam int CNT_W      = 7;
  localparam int STAT_W     = 2;
  localparam int RESULT_CAP = 64;

  // operation codes
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADID = 2'd3;

  // register byte address
  localparam logic [1:0] REG_VLEN_ADDR = 2'd0;

  typedef enum logic [1:0] {
    EMIT_STATUS,
    EMIT_ELEM,
    EMIT_NEIGH
  } emit_kind_e;

  // controller to datapath
  typedef struct packed {
    logic              accept;
    logic              qbuf_wr;
    logic              id_rd;
    logic              id_wr;
    logic              id_zero;
    logic              vec_zero;
    logic              vec_rd;
    logic              copy_rd;
    logic              mac_issue;
    logic              mac_first;
    logic              mac_last;
    logic              sort_clear;
    logic              sort_insert;
    logic              sort_shift;
    logic              emit;
    emit_kind_e        emit_kind;
    logic [STAT_W-1:0] emit_status;
    logic              emit_last;
  } vtk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_id_zero;
    logic in_k_zero;
    logic id_match;
    logic id_free;
    logic dist_done;
    logic n_zero;
    logic n_one;
    logic out_free;
  } vtk_sts_t;

  // ordering of candidates: smaller distance first, then lower id
  function automatic logic vtk_better(input logic [DIST_W-1:0] d,
                                      input logic [ID_W-1:0]   id,
                                      input logic [DIST_W-1:0] od,
                                      input logic [ID_W-1:0]   oid);
    return (d < od) || ((d == od) && (id < oid));
  endfunction

endpackage
`default_nettype wire

/* src/vtk_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtk_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vtk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/vtk_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtk_dp
// Datapath: slot id, vector and query memories, distance accumulator,
// sorted best list and output register.
// ----------------------------------------------------------------------------
module vtk_dp #(
  parameter int SLOTS      = 64,
  parameter int MAX_LENGTH = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [31:0]             in_node_id_i,
  input  wire logic signed [15:0]      in_element_i,
  input  wire logic [6:0]              in_k_i,
  input  vtk_pkg::vtk_cmd_t            cmd_i,
  input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]           slot_i,
  input  wire logic [((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1)-1:0] elem_i,
  input  wire logic [((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1)-1:0] pos_i,
  input  wire logic [6:0]              occ_i,
  output vtk_pkg::vtk_sts_t            sts_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [31:0]                  out_result_id_o,
  output logic [37:0]                  out_distance_o,
  output logic signed [15:0]           out_element_o,
  output logic [1:0]                   out_status_o,
  output logic [6:0]                   out_occupied_o,
  output logic                         out_last_o
);

  import vtk_pkg::*;

  localparam int VDEPTH = SLOTS * MAX_LENGTH;
  localparam int VW     = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

  logic [ID_W-1:0]   id_q;
  logic [CNT_W-1:0]  k_q;
  logic [VW-1:0]     vaddr;
  logic [ID_W-1:0]   id_rdata;
  logic [ELEM_W-1:0] qb_rdata;
  logic [ELEM_W-1:0] vec_rdata;
  logic              copy_wr_q;
  logic [VW-1:0]     copy_addr_q;
  logic              vec_we;
  logic [VW-1:0]     vec_waddr;
  logic [ELEM_W-1:0] vec_wdata;

  // latch operation arguments on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      id_q <= in_node_id_i;
      k_q  <= (in_k_i > CNT_W'(RESULT_CAP)) ? CNT_W'(RESULT_CAP) : in_k_i;
    end
  end

  assign vaddr = VW'(slot_i) * VW'(MAX_LENGTH) + VW'(elem_i);

  // slot id table
  vtk_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.id_wr),
    .waddr_i (slot_i),
    .wdata_i (cmd_i.id_zero ? '0 : id_q),
    .re_i    (cmd_i.id_rd),
    .raddr_i (slot_i),
    .rdata_o (id_rdata)
  );

  // collected set or query vector
  vtk_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LENGTH)) u_qbuf_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.qbuf_wr),
    .waddr_i (pos_i),
    .wdata_i (in_element_i),
    .re_i    (cmd_i.copy_rd | cmd_i.mac_issue),
    .raddr_i (elem_i),
    .rdata_o (qb_rdata)
  );

  // copy writes land in the cycle after the query buffer read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_wr_q <= 1'b0;
    end else begin
      copy_wr_q <= cmd_i.copy_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    copy_addr_q <= vaddr;
  end

  assign vec_we    = copy_wr_q | cmd_i.vec_zero;
  assign vec_waddr = copy_wr_q ? copy_addr_q : vaddr;
  assign vec_wdata = copy_wr_q ? qb_rdata : '0;

  // stored vectors
  vtk_ram #(.WIDTH(ELEM_W), .DEPTH(VDEPTH)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (vec_waddr),
    .wdata_i (vec_wdata),
    .re_i    (cmd_i.vec_rd | cmd_i.mac_issue),
    .raddr_i (vaddr),
    .rdata_o (vec_rdata)
  );

  // distance pipeline: read, square, accumulate
  logic                 v1_q, f1_q, l1_q;
  logic                 v2_q, f2_q, l2_q;
  logic signed [16:0]   diff;
  logic signed [33:0]   sq;
  logic [33:0]          prod_q;
  logic [DIST_W-1:0]    acc_q;
  logic                 done_q;

  assign diff = $signed({vec_rdata[ELEM_W-1], vec_rdata})
              - $signed({qb_rdata[ELEM_W-1], qb_rdata});
  assign sq   = diff * diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= cmd_i.mac_issue;
      v2_q   <= v1_q;
      done_q <= v2_q & l2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q   <= cmd_i.mac_first;
    l1_q   <= cmd_i.mac_last;
    f2_q   <= f1_q;
    l2_q   <= l1_q;
    prod_q <= $unsigned(sq);
    if (v2_q) begin
      acc_q <= (f2_q ? '0 : acc_q) + DIST_W'(prod_q);
    end
  end

  // sorted best list, a row of cells with parallel insertion
  logic [DIST_W-1:0] cdist_q [RESULT_CAP];
  logic [ID_W-1:0]   cid_q   [RESULT_CAP];
  logic [CNT_W-1:0]  n_q;
  logic [RESULT_CAP-1:0] better_v;

  always_comb begin
    for (int i = 0; i < RESULT_CAP; i++) begin
      better_v[i] = (CNT_W'(i) >= n_q) ? 1'b1
                  : vtk_better(acc_q, id_rdata, cdist_q[i], cid_q[i]);
    end
  end

  for (genvar g = 0; g < RESULT_CAP; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.sort_insert && (CNT_W'(g) < k_q) && better_v[g]) begin
        if (g > 0 && better_v[(g > 0) ? g - 1 : 0]) begin
          cdist_q[g] <= cdist_q[(g > 0) ? g - 1 : 0];
          cid_q[g]   <= cid_q[(g > 0) ? g - 1 : 0];
        end else begin
          cdist_q[g] <= acc_q;
          cid_q[g]   <= id_rdata;
        end
      end else if (cmd_i.sort_shift && g < RESULT_CAP - 1) begin
        cdist_q[g] <= cdist_q[(g < RESULT_CAP - 1) ? g + 1 : g];
        cid_q[g]   <= cid_q[(g < RESULT_CAP - 1) ? g + 1 : g];
      end
    end
  end

  // occupancy of the best list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (cmd_i.sort_clear) begin
      n_q <= '0;
    end else if (cmd_i.sort_insert && (n_q < k_q)) begin
      n_q <= n_q + 1'b1;
    end else if (cmd_i.sort_shift && (n_q != '0)) begin
      n_q <= n_q - 1'b1;
    end
  end

  // output register
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_o   <= cmd_i.emit_status;
      out_occupied_o <= occ_i;
      out_last_o     <= cmd_i.emit_last;
      case (cmd_i.emit_kind)
        EMIT_ELEM: begin
          out_result_id_o <= id_q;
          out_distance_o  <= '0;
          out_element_o   <= vec_rdata;
        end
        EMIT_NEIGH: begin
          out_result_id_o <= cid_q[0];
          out_distance_o  <= cdist_q[0];
          out_element_o   <= '0;
        end
        default: begin
          out_result_id_o <= (cmd_i.emit_status == STAT_OK) ? id_q : '0;
          out_distance_o  <= '0;
          out_element_o   <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  // status towards the controller
  always_comb begin
    sts_o.in_id_zero = (in_node_id_i == '0);
    sts_o.in_k_zero  = (in_k_i == '0);
    sts_o.id_match   = (id_rdata == id_q);
    sts_o.id_free    = (id_rdata == '0);
    sts_o.dist_done  = done_q;
    sts_o.n_zero     = (n_q == '0);
    sts_o.n_one      = (n_q == CNT_W'(1));
    sts_o.out_free   = out_free;
  end

endmodule
`default_nettype wire

/* src/vtk_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtk_ctrl
// Controller: sequences clearing, slot lookup, vector copy, get, remove,
// search and result emission.
// ----------------------------------------------------------------------------
module vtk_ctrl #(
  parameter int SLOTS      = 64,
  parameter int MAX_LENGTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       op_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [6:0]       len_i,
  input  vtk_pkg::vtk_sts_t     sts_i,
  output vtk_pkg::vtk_cmd_t     cmd_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]           slot_o,
  output logic [((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1)-1:0] elem_o,
  output logic [((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1)-1:0] pos_o,
  output logic [6:0]            occ_o
);

  import vtk_pkg::*;

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CW    = (EW + 1 > CNT_W) ? EW + 1 : CNT_W;
  localparam int ENT_W = $clog2(SLOTS + 1);

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_FIND_RD   = 5'd2;
  localparam logic [4:0] S_FIND_CHK  = 5'd3;
  localparam logic [4:0] S_SET_ID    = 5'd4;
  localparam logic [4:0] S_COPY      = 5'd5;
  localparam logic [4:0] S_REM_ID    = 5'd6;
  localparam logic [4:0] S_ZERO      = 5'd7;
  localparam logic [4:0] S_GET_RD    = 5'd8;
  localparam logic [4:0] S_GET_OUT   = 5'd9;
  localparam logic [4:0] S_SRCH_RD   = 5'd10;
  localparam logic [4:0] S_SRCH_CHK  = 5'd11;
  localparam logic [4:0] S_SRCH_MAC  = 5'd12;
  localparam logic [4:0] S_SRCH_WAIT = 5'd13;
  localparam logic [4:0] S_SRCH_END  = 5'd14;
  localparam logic [4:0] S_NB_OUT    = 5'd15;
  localparam logic [4:0] S_EMIT      = 5'd16;

  logic [4:0]        state_q, state_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [SW-1:0]     free_q, free_d;
  logic              have_free_q, have_free_d;
  logic [EW-1:0]     elem_q, elem_d;
  logic [EW-1:0]     pos_q, pos_d;
  logic [1:0]        op_q, op_d;
  logic [STAT_W-1:0] code_q, code_d;
  logic [ENT_W-1:0]  entry_q, entry_d;

  logic          accept;
  logic [CW-1:0] len_m1;
  logic          elem_last;
  logic          elem_end;
  logic          slot_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign len_m1     = CW'(len_i) - CW'(1);
  assign elem_last  = (CW'(elem_q) == len_m1);
  assign elem_end   = (elem_q == EW'(MAX_LENGTH - 1));
  assign slot_last  = (slot_q == SW'(SLOTS - 1));

  // next state and commands
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    free_d      = free_q;
    have_free_d = have_free_q;
    elem_d      = elem_q;
    pos_d       = pos_q;
    op_d        = op_q;
    code_d      = code_q;
    entry_d     = entry_q;
    cmd_o             = '0;
    cmd_o.emit_kind   = EMIT_STATUS;
    cmd_o.emit_status = STAT_OK;

    case (state_q)
      S_CLEAR: begin
        cmd_o.vec_zero = 1'b1;
        if (elem_q == '0) begin
          cmd_o.id_wr   = 1'b1;
          cmd_o.id_zero = 1'b1;
        end
        if (elem_end) begin
          elem_d = '0;
          if (slot_last) begin
            slot_d  = '0;
            state_d = S_IDLE;
          end else begin
            slot_d = slot_q + 1'b1;
          end
        end else begin
          elem_d = elem_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          op_d         = op_i;
          slot_d       = '0;
          elem_d       = '0;
          have_free_d  = 1'b0;
          if (op_i inside {OP_GET, OP_REMOVE}) begin
            pos_d = '0;
            if (sts_i.in_id_zero) begin
              code_d  = STAT_BADID;
              state_d = S_EMIT;
            end else begin
              state_d = S_FIND_RD;
            end
          end else begin
            cmd_o.qbuf_wr = 1'b1;
            if (CW'(pos_q) + CW'(1) < CW'(len_i)) begin
              pos_d = pos_q + 1'b1;
            end else begin
              pos_d = '0;
              if (op_i == OP_SET) begin
                if (sts_i.in_id_zero) begin
                  code_d  = STAT_BADID;
                  state_d = S_EMIT;
                end else begin
                  state_d = S_FIND_RD;
                end
              end else if (sts_i.in_k_zero) begin
                code_d  = STAT_NONE;
                state_d = S_EMIT;
              end else begin
                cmd_o.sort_clear = 1'b1;
                state_d          = S_SRCH_RD;
              end
            end
          end
        end
      end

      S_FIND_RD: begin
        cmd_o.id_rd = 1'b1;
        state_d     = S_FIND_CHK;
      end

      S_FIND_CHK: begin
        if (sts_i.id_match) begin
          case (op_q)
            OP_SET:    state_d = S_COPY;
            OP_GET:    state_d = S_GET_RD;
            OP_REMOVE: state_d = S_REM_ID;
            default:   state_d = S_IDLE;
          endcase
        end else begin
          if (sts_i.id_free && !have_free_q) begin
            free_d      = slot_q;
            have_free_d = 1'b1;
          end
          if (slot_last) begin
            if (op_q != OP_SET) begin
              code_d  = STAT_NONE;
              state_d = S_EMIT;
            end else if (have_free_q || sts_i.id_free) begin
              slot_d  = have_free_q ? free_q : slot_q;
              state_d = S_SET_ID;
            end else begin
              code_d  = STAT_FULL;
              state_d = S_EMIT;
            end
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = S_FIND_RD;
          end
        end
      end

      S_SET_ID: begin
        cmd_o.id_wr = 1'b1;
        entry_d     = entry_q + 1'b1;
        state_d     = S_COPY;
      end

      // query buffer into the slot's vector
      S_COPY: begin
        cmd_o.copy_rd = 1'b1;
        if (elem_last) begin
          elem_d  = '0;
          code_d  = STAT_OK;
          state_d = S_EMIT;
        end else begin
          elem_d = elem_q + 1'b1;
        end
      end

      S_REM_ID: begin
        cmd_o.id_wr   = 1'b1;
        cmd_o.id_zero = 1'b1;
        if (entry_q != '0) begin
          entry_d = entry_q - 1'b1;
        end
        state_d = S_ZERO;
      end

      // zero the whole vector of a removed slot
      S_ZERO: begin
        cmd_o.vec_zero = 1'b1;
        if (elem_end) begin
          elem_d  = '0;
          code_d  = STAT_OK;
          state_d = S_EMIT;
        end else begin
          elem_d = elem_q + 1'b1;
        end
      end

      S_GET_RD: begin
        cmd_o.vec_rd = 1'b1;
        state_d      = S_GET_OUT;
      end

      S_GET_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EMIT_ELEM;
          cmd_o.emit_last = elem_last;
          if (elem_last) begin
            elem_d  = '0;
            state_d = S_IDLE;
          end else begin
            elem_d  = elem_q + 1'b1;
            state_d = S_GET_RD;
          end
        end
      end

      S_SRCH_RD: begin
        cmd_o.id_rd = 1'b1;
        state_d     = S_SRCH_CHK;
      end

      S_SRCH_CHK: begin
        if (sts_i.id_free) begin
          if (slot_last) begin
            state_d = S_SRCH_END;
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = S_SRCH_RD;
          end
        end else begin
          elem_d  = '0;
          state_d = S_SRCH_MAC;
        end
      end

      // one element of the slot's distance per cycle
      S_SRCH_MAC: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.mac_first = (elem_q == '0);
        cmd_o.mac_last  = elem_last;
        if (elem_last) begin
          elem_d  = '0;
          state_d = S_SRCH_WAIT;
        end else begin
          elem_d = elem_q + 1'b1;
        end
      end

      S_SRCH_WAIT: begin
        if (sts_i.dist_done) begin
          cmd_o.sort_insert = 1'b1;
          if (slot_last) begin
            state_d = S_SRCH_END;
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = S_SRCH_RD;
          end
        end
      end

      S_SRCH_END: begin
        if (sts_i.n_zero) begin
          code_d  = STAT_NONE;
          state_d = S_EMIT;
        end else begin
          state_d = S_NB_OUT;
        end
      end

      S_NB_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_kind  = EMIT_NEIGH;
          cmd_o.emit_last  = sts_i.n_one;
          cmd_o.sort_shift = 1'b1;
          if (sts_i.n_one) begin
            state_d = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = code_q;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      slot_q      <= '0;
      free_q      <= '0;
      have_free_q <= 1'b0;
      elem_q      <= '0;
      pos_q       <= '0;
      op_q        <= OP_SET;
      code_q      <= STAT_OK;
      entry_q     <= '0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      free_q      <= free_d;
      have_free_q <= have_free_d;
      elem_q      <= elem_d;
      pos_q       <= pos_d;
      op_q        <= op_d;
      code_q      <= code_d;
      entry_q     <= entry_d;
    end
  end

  assign slot_o = slot_q;
  assign elem_o = elem_q;
  assign pos_o  = pos_q;
  assign occ_o  = CNT_W'(entry_q);

  // a result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result loaded into a busy output register");

  // insertion only with a finished distance
  a_insert_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sort_insert |-> sts_i.dist_done)
    else $error("best list insertion without a finished distance");

  // occupancy never exceeds the table size
  a_entry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_q <= ENT_W'(SLOTS))
    else $error("occupied count beyond table size");

endmodule
`default_nettype wire

/* src/vector_table_knn_search_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_table_knn_search_core
// Id-keyed vector table with brute-force k-nearest search (squared distance).
// ----------------------------------------------------------------------------
// After reset the core clears its tables slot by slot and takes no
// transaction until that pass ends. Items are taken one operation at a time.
// Set and query elements that do not complete a vector are only stored in the
// query buffer. A completed set looks up its slot through the id memory,
// reading and then checking each slot, then copies the vector element by
// element; get does the same lookup, then reads and emits each element, and
// remove clears the id and zeroes the whole vector. A search visits every
// slot, accumulates the distance of each occupied one, then returns the
// neighbours in order. Result transactions wait in an output register, so a
// new item can be taken while the last result is still held.
module vector_table_knn_search_core #(
  parameter int SLOTS      = 64,
  parameter int MAX_LENGTH = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // node_id [31:0], element_value [47:32], neighbor_count [54:48], zero pad
  input  wire logic [55:0]  s_axis_tdata,
  // operation [1:0]
  input  wire logic [1:0]   s_axis_tuser,
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_id [31:0], distance [69:32], element_out [85:70], status [87:86],
  // occupied_count [94:88], zero pad [95]
  output logic [95:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import vtk_pkg::*;

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LMAX = (MAX_LENGTH < RESULT_CAP) ? MAX_LENGTH : RESULT_CAP;

  logic [CNT_W-1:0] vlen_q;
  logic [CNT_W-1:0] len;

  // vector length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= CNT_W'(64);
    end else if (psel && penable && pwrite && pready && (paddr == REG_VLEN_ADDR)) begin
      vlen_q <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_VLEN_ADDR) ? {25'd0, vlen_q} : '0;

  // effective length: zero taken as one, clamped to the smaller of MAX_LENGTH and RESULT_CAP
  assign len = (vlen_q == '0) ? CNT_W'(1)
             : (vlen_q > CNT_W'(LMAX)) ? CNT_W'(LMAX) : vlen_q;

  vtk_cmd_t          cmd;
  vtk_sts_t          sts;
  logic [SW-1:0]     slot;
  logic [EW-1:0]     elem;
  logic [EW-1:0]     pos;
  logic [CNT_W-1:0]  occ;
  logic [ID_W-1:0]   out_result_id;
  logic [DIST_W-1:0] out_distance;
  logic [ELEM_W-1:0] out_element;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_occupied;

  vtk_ctrl #(.SLOTS(SLOTS), .MAX_LENGTH(MAX_LENGTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (s_axis_tuser),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .len_i      (len),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .slot_o     (slot),
    .elem_o     (elem),
    .pos_o      (pos),
    .occ_o      (occ)
  );

  vtk_dp #(.SLOTS(SLOTS), .MAX_LENGTH(MAX_LENGTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_node_id_i    (s_axis_tdata[31:0]),
    .in_element_i    (s_axis_tdata[47:32]),
    .in_k_i          (s_axis_tdata[54:48]),
    .cmd_i           (cmd),
    .slot_i          (slot),
    .elem_i          (elem),
    .pos_i           (pos),
    .occ_i           (occ),
    .sts_o           (sts),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_result_id_o (out_result_id),
    .out_distance_o  (out_distance),
    .out_element_o   (out_element),
    .out_status_o    (out_status),
    .out_occupied_o  (out_occupied),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_occupied, out_status, out_element,
                         out_distance, out_result_id};

endmodule
`default_nettype wire

/* verif/vector_table_knn_search_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_table_knn_search_core_tb
// Drives set, get, remove and search streams into the vector table core under
// several vector lengths. A built-in model of the table predicts every result
// transaction, which is checked field by field as it leaves the core.
// ----------------------------------------------------------------------------
module vector_table_knn_search_core_tb;
  import vtk_pkg::*;

  localparam int NSLOT      = 64;
  localparam int MAXLEN     = 64;
  localparam int IDLE_LIMIT = 60000;
  localparam int SETTLE     = 400;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
    logic [ELEM_W-1:0] elem;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  occ;
    logic              last;
  } knn_result_t;

  // table model and queue of predicted results
  class knn_scoreboard;
    logic [ID_W-1:0]          slot_id[NSLOT];
    logic signed [ELEM_W-1:0] slot_vec[NSLOT][MAXLEN];
    logic signed [ELEM_W-1:0] qbuf[MAXLEN];
    int unsigned              total;
    int unsigned              position;
    int unsigned              vlen;
    knn_result_t              pending_q[$];
    int                       errors;

    function void clear();
      foreach (slot_id[i]) slot_id[i] = '0;
      foreach (slot_vec[i, j]) slot_vec[i][j] = '0;
      foreach (qbuf[i]) qbuf[i] = '0;
      total = 0;
      position = 0;
      vlen = 64;
      errors = 0;
    endfunction

    function int unsigned eff_len();
      int unsigned v;
      v = vlen;
      if (v == 0) v = 1;
      if (v > MAXLEN) v = MAXLEN;
      return v;
    endfunction

    function void push(logic [ID_W-1:0] id, logic [DIST_W-1:0] sq_dist,
                       logic [ELEM_W-1:0] elem, logic [STAT_W-1:0] st, logic last);
      knn_result_t r;
      r.id = id; r.sq_dist = sq_dist; r.elem = elem; r.status = st;
      r.occ = total[CNT_W-1:0]; r.last = last;
      pending_q.push_back(r);
    endfunction

    function int find_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < NSLOT; i++) if (slot_id[i] == id) return i;
      return NSLOT;
    endfunction

    function bit closer(longint unsigned d, logic [ID_W-1:0] id,
                        longint unsigned od, logic [ID_W-1:0] oid);
      return (d < od) || (d == od && id < oid);
    endfunction

    // accepted input transaction
    function void note_input(logic [1:0] op, logic [ID_W-1:0] id,
                             logic signed [ELEM_W-1:0] elem, logic [CNT_W-1:0] k);
      int unsigned len, pos, n, kk;
      int s;
      longint unsigned dsum, bd[RESULT_CAP];
      logic [ID_W-1:0] bi[RESULT_CAP];
      int diff;
      len = eff_len();
      if (op == OP_GET || op == OP_REMOVE) begin
        position = 0;
        if (id == 0) begin push(0, 0, 0, STAT_BADID, 1); return; end
        s = find_slot(id);
        if (s >= NSLOT) begin push(0, 0, 0, STAT_NONE, 1); return; end
        if (op == OP_GET) begin
          for (int d = 0; d < len; d++) push(id, 0, slot_vec[s][d], STAT_OK, d == len - 1);
          return;
        end
        slot_id[s] = '0;
        for (int d = 0; d < MAXLEN; d++) slot_vec[s][d] = '0;
        if (total > 0) total--;
        push(id, 0, 0, STAT_OK, 1);
        return;
      end
      // element of a set or query stream
      pos = position;
      if (pos >= MAXLEN) pos = 0;
      qbuf[pos] = elem;
      if (pos + 1 < len) begin position = pos + 1; return; end
      position = 0;
      if (op == OP_SET) begin
        if (id == 0) begin push(0, 0, 0, STAT_BADID, 1); return; end
        s = find_slot(id);
        if (s >= NSLOT) begin
          s = find_slot(0);
          if (s >= NSLOT) begin push(0, 0, 0, STAT_FULL, 1); return; end
          slot_id[s] = id;
          total++;
        end
        for (int d = 0; d < len; d++) slot_vec[s][d] = qbuf[d];
        push(id, 0, 0, STAT_OK, 1);
        return;
      end
      // search: keep the kk best in order
      kk = (k > RESULT_CAP) ? RESULT_CAP : k;
      n = 0;
      if (kk > 0) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_id[i] == 0) continue;
          dsum = 0;
          for (int d = 0; d < len; d++) begin
            diff = int'(slot_vec[i][d]) - int'(qbuf[d]);
            dsum += longint'(diff) * longint'(diff);
          end
          if (n == kk && !closer(dsum, slot_id[i], bd[n-1], bi[n-1])) continue;
          if (n < kk) n++;
          pos = n - 1;
          while (pos > 0 && closer(dsum, slot_id[i], bd[pos-1], bi[pos-1])) begin
            bd[pos] = bd[pos-1];
            bi[pos] = bi[pos-1];
            pos--;
          end
          bd[pos] = dsum;
          bi[pos] = slot_id[i];
        end
      end
      if (n == 0) begin push(0, 0, 0, STAT_NONE, 1); return; end
      for (int i = 0; i < n; i++) push(bi[i], bd[i][DIST_W-1:0], 0, STAT_OK, i == n - 1);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    // accepted result transaction
    task check_result(logic [95:0] data, logic last);
      knn_result_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result", data[31:0], 0);
        return;
      end
      w = pending_q.pop_front();
      if (data[31:0]  !== w.id)      report("result_id", data[31:0], w.id);
      if (data[69:32] !== w.sq_dist) report("distance", data[69:32], w.sq_dist);
      if (data[85:70] !== w.elem)    report("element_out", data[85:70], w.elem);
      if (data[87:86] !== w.status)  report("status", data[87:86], w.status);
      if (data[94:88] !== w.occ)     report("occupied_count", data[94:88], w.occ);
      if (last !== w.last)           report("tlast", last, w.last);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  knn_scoreboard table_sb;
  int          items_sent;
  int          burst_left;
  int          idle_cycles = 0;
  int          ready_mode = 0;
  int          mode_cycles = 0;

  vector_table_knn_search_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // monitor both streams
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      table_sb.note_input(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32],
                          s_axis_tdata[54:48]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      table_sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // receiver stall pattern, mode changes every so often
  always @(posedge clk_i) begin
    if (mode_cycles == 0) begin
      ready_mode  <= $urandom_range(0, 3);
      mode_cycles <= $urandom_range(50, 300);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= mode_cycles[2];
    endcase
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("vector_table_knn_search_core_tb failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      2: return 32'hffff_ffff;
      default: return 32'($urandom_range(1, 12));
    endcase
  endfunction

  // one input transaction, with bursts and gaps
  task automatic send_item(logic [1:0] op, logic [31:0] id, logic [15:0] elem,
                           logic [6:0] k);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, k, elem, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic send_vector(logic [1:0] op, logic [31:0] id, logic [6:0] k);
    int unsigned len;
    len = table_sb.eff_len();
    for (int d = 0; d < len - 1; d++) send_item(op, $urandom, pick_elem(), 7'($urandom));
    send_item(op, id, pick_elem(), k);
  endtask

  task automatic send_pair(logic [1:0] op, logic [31:0] id, logic [6:0] k,
                           logic [15:0] a, logic [15:0] b);
    send_item(op, $urandom, a, 7'($urandom));
    send_item(op, id, b, k);
  endtask

  // stop sending and wait for every predicted result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (table_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // register write while idle
  task automatic set_length(logic [6:0] value);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_VLEN_ADDR;
    pwdata  <= {25'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    table_sb.vlen = {25'd0, value};
  endtask

  task automatic random_phase(int budget);
    int stop_at;
    int sel;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)      send_vector(OP_SET, pick_id(), 7'($urandom_range(0, 127)));
      else if (sel < 72) send_vector(OP_QUERY, pick_id(), ($urandom_range(0, 3) == 0) ?
                                     7'($urandom_range(0, 127)) :
                                     7'($urandom_range(1, 6)));
      else if (sel < 84) send_item(OP_GET, pick_id(), 16'($urandom), 7'($urandom));
      else if (sel < 92) send_item(OP_REMOVE, pick_id(), 16'($urandom), 7'($urandom));
      else               send_item(2'($urandom), $urandom, 16'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    table_sb = new();
    table_sb.clear();
    items_sent  = 0;
    burst_left  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at two elements per vector
    set_length(7'd2);
    send_item(OP_GET, 32'd0, 16'h0, 7'd0);
    send_item(OP_REMOVE, 32'd5, 16'h0, 7'd0);
    send_pair(OP_QUERY, 32'd1, 7'd3, 16'h0001, 16'h0002);
    send_pair(OP_SET, 32'd0, 7'd0, 16'h1234, 16'h4321);
    send_pair(OP_SET, 32'd5, 7'd0, 16'h7fff, 16'h8000);
    send_pair(OP_SET, 32'hffff_ffff, 7'd0, 16'h8000, 16'h7fff);
    send_pair(OP_SET, 32'd9, 7'd0, 16'h0000, 16'h0000);
    send_pair(OP_SET, 32'd7, 7'd0, 16'h0000, 16'h0000);
    send_pair(OP_QUERY, 32'd0, 7'd0, 16'h0000, 16'h0000);
    send_pair(OP_QUERY, 32'd0, 7'd127, 16'h0010, 16'h0000);
    send_pair(OP_QUERY, 32'd0, 7'd1, 16'h0000, 16'h0000);
    send_item(OP_GET, 32'd5, 16'h0, 7'd0);
    // get in the middle of a set stream drops the partial vector
    send_item(OP_SET, 32'd11, 16'h5555, 7'd0);
    send_item(OP_GET, 32'd9, 16'h0, 7'd0);
    send_item(OP_REMOVE, 32'd5, 16'h0, 7'd0);
    send_item(OP_GET, 32'd5, 16'h0, 7'd0);

    // hold off until the core has answered everything
    drain();

    // single-element vectors: fill the table, overflow it, search, free some
    set_length(7'd1);
    for (int i = 0; i < 66; i++) send_item(OP_SET, 32'h1000 + i, pick_elem(), 7'($urandom));
    send_item(OP_QUERY, 32'd0, pick_elem(), 7'd64);
    send_item(OP_QUERY, 32'd0, pick_elem(), 7'd5);
    for (int i = 0; i < 20; i++) send_item(OP_REMOVE, 32'h1000 + 3 * i, 16'h0, 7'd0);

    set_length(7'd64);
    random_phase(100);
    set_length(7'd0);
    random_phase(30);
    set_length(7'd5);
    random_phase(50);
    set_length(7'd127);
    random_phase(50);

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (table_sb.errors == 0 && table_sb.pending_q.size() == 0)
      $display("vector_table_knn_search_core_tb passed");
    else
      $display("vector_table_knn_search_core_tb failed");
    $finish;
  end

endmodule
